// ===== src/lcdts_pkg.sv =====
// lcdts_pkg: shared types, constants and helpers for the lcd line timing block
package lcdts_pkg;

  // fixed field widths
  localparam int unsigned TICK_W   = 9;
  localparam int unsigned DOT_W    = 9;
  localparam int unsigned LINE_W   = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned LMODE_W  = 3;
  localparam int unsigned LYC_W    = 8;
  localparam int unsigned STATEN_W = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  // default timing
  localparam int unsigned DOTS_PER_LINE_DEF = 456;
  localparam int unsigned VISIBLE_LINES_DEF = 144;

  localparam logic [LINE_W-1:0] LAST_LINE    = 8'd153;
  localparam logic [DOT_W-1:0]  OAM_END_DOT  = 9'd80;
  localparam logic [DOT_W-1:0]  DRAW_END_DOT = 9'd252;

  // lcd modes
  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd3;
  localparam logic [LMODE_W-1:0] NO_MODE    = 3'd7;

  // stat enable bit positions
  localparam int unsigned STAT_EN_HBLANK = 0;
  localparam int unsigned STAT_EN_VBLANK = 1;
  localparam int unsigned STAT_EN_OAM    = 2;
  localparam int unsigned STAT_EN_LYC    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LCD_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LYC_VALUE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STAT_ENABLES = 2'd2;

  typedef struct packed {
    logic [DOT_W-1:0]   dot;
    logic [LINE_W-1:0]  line;
    logic [MODE_W-1:0]  mode;
    logic [LMODE_W-1:0] last_mode;
    logic               cmatch;
  } lcdts_state_t;

  typedef struct packed {
    logic               lcd_enable;
    logic [LYC_W-1:0]   lyc_value;
    logic [STATEN_W-1:0] stat_enables;
  } lcdts_cfg_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    logic [MODE_W-1:0] mode;
    logic              lyc_equal;
    logic              vblank_request;
    logic              stat_request;
    logic              render_valid;
    logic [LINE_W-1:0] render_line;
  } lcdts_result_t;

  // stat enable bit that belongs to a mode; drawing has none
  function automatic logic mode_stat_en(input logic [MODE_W-1:0] m,
                                        input logic [STATEN_W-1:0] en);
    logic r;
    case (m)
      MODE_HBLANK: r = en[STAT_EN_HBLANK];
      MODE_VBLANK: r = en[STAT_EN_VBLANK];
      MODE_OAM:    r = en[STAT_EN_OAM];
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/lcdts_step.sv =====
// lcdts_step: one tick item applied to the timing state, next state and result
module lcdts_step #(
  parameter int unsigned DOTS_PER_LINE = lcdts_pkg::DOTS_PER_LINE_DEF,
  parameter int unsigned VISIBLE_LINES = lcdts_pkg::VISIBLE_LINES_DEF
) (
  input  logic [lcdts_pkg::TICK_W-1:0] tick_count,
  input  lcdts_pkg::lcdts_cfg_t        cfg,
  input  lcdts_pkg::lcdts_state_t      state,
  output lcdts_pkg::lcdts_state_t      state_nxt,
  output lcdts_pkg::lcdts_result_t     result
);
  import lcdts_pkg::*;

  localparam logic [DOT_W-1:0]  DPL  = DOT_W'(DOTS_PER_LINE);
  localparam logic [DOT_W:0]    DPL1 = (DOT_W+1)'(DOTS_PER_LINE);
  localparam logic [LINE_W-1:0] VIS  = LINE_W'(VISIBLE_LINES);

  logic [DOT_W-1:0]   tick_sat;
  logic [DOT_W:0]     dot_sum;
  logic               boundary;
  logic [DOT_W-1:0]   dot_n;
  logic [LINE_W-1:0]  line_inc;
  logic [LINE_W-1:0]  line_a;
  logic               ent1;
  logic [MODE_W-1:0]  code1;
  logic               vblank;
  logic [MODE_W-1:0]  mode_a;
  logic [LMODE_W-1:0] lm_a;
  logic               fire1;
  logic               match;
  logic               fire_c;
  logic               cmatch_n;
  logic [MODE_W-1:0]  code2;
  logic               fire2;
  logic [MODE_W-1:0]  mode_n;
  logic [LMODE_W-1:0] lm_n;
  logic               rvalid;

  always_comb begin
    tick_sat = (tick_count > DPL) ? DPL : tick_count;
    dot_sum  = {1'b0, state.dot} + {1'b0, tick_sat};
    boundary = (dot_sum >= DPL1);
    dot_n    = boundary ? DOT_W'(dot_sum - DPL1) : dot_sum[DOT_W-1:0];
    line_inc = state.line + LINE_W'(1);
    rvalid   = boundary && (state.line < VIS);

    // line boundary: advance the line and pick the entry mode
    line_a = state.line;
    ent1   = 1'b0;
    code1  = MODE_OAM;
    vblank = 1'b0;
    if (boundary) begin
      line_a = line_inc;
      if (line_inc == VIS) begin
        vblank = 1'b1;
        ent1   = 1'b1;
        code1  = MODE_VBLANK;
      end else if (line_inc > LAST_LINE) begin
        line_a = '0;
      end else if (line_inc < VIS) begin
        ent1  = 1'b1;
        code1 = MODE_OAM;
      end
    end
    mode_a = ent1 ? code1 : state.mode;
    lm_a   = ent1 ? {1'b0, code1} : state.last_mode;
    fire1  = ent1 && ({1'b0, code1} != state.last_mode) &&
             mode_stat_en(code1, cfg.stat_enables);

    // line compare, rising edge only
    match    = (line_a == cfg.lyc_value);
    fire_c   = boundary && match && !state.cmatch && cfg.stat_enables[STAT_EN_LYC];
    cmatch_n = boundary ? match : state.cmatch;

    // dot position mode on visible lines
    if (dot_n < OAM_END_DOT) begin
      code2 = MODE_OAM;
    end else if (dot_n < DRAW_END_DOT) begin
      code2 = MODE_DRAW;
    end else begin
      code2 = MODE_HBLANK;
    end
    if (line_a < VIS) begin
      mode_n = code2;
      lm_n   = {1'b0, code2};
      fire2  = ({1'b0, code2} != lm_a) && mode_stat_en(code2, cfg.stat_enables);
    end else begin
      mode_n = mode_a;
      lm_n   = lm_a;
      fire2  = 1'b0;
    end

    if (cfg.lcd_enable) begin
      state_nxt.dot       = dot_n;
      state_nxt.line      = line_a;
      state_nxt.mode      = mode_n;
      state_nxt.last_mode = lm_n;
      state_nxt.cmatch    = cmatch_n;
      result.line_number    = line_a;
      result.mode           = mode_n;
      result.lyc_equal      = cmatch_n;
      result.vblank_request = vblank;
      result.stat_request   = fire1 | fire_c | fire2;
      result.render_valid   = rvalid;
      result.render_line    = rvalid ? state.line : '0;
    end else begin
      // display off: timing held at zero, edge memories kept
      state_nxt.dot       = '0;
      state_nxt.line      = '0;
      state_nxt.mode      = MODE_HBLANK;
      state_nxt.last_mode = state.last_mode;
      state_nxt.cmatch    = state.cmatch;
      result.line_number    = '0;
      result.mode           = MODE_HBLANK;
      result.lyc_equal      = state.cmatch;
      result.vblank_request = 1'b0;
      result.stat_request   = 1'b0;
      result.render_valid   = 1'b0;
      result.render_line    = '0;
    end
  end

endmodule

// ===== src/lcd_line_timing_stat_irq_core.sv =====
// lcd_line_timing_stat_irq_core: lcd scanline timing with stat and vblank requests
//
//  channel | dir | handshake           | content
//  --------+-----+---------------------+----------------------------------------
//  in_     | in  | tvalid/tready       | tick_count per transfer
//  out_    | out | tvalid/tready       | line, mode, compare flag, requests
//  cfg_    | in  | cfg_we, no wait     | lcd_enable, lyc_value, stat_enables
//
// flow: one transfer in per clock while out_tready stays high; each tick count
//   passes the input register, then the step logic into the result register,
//   whose contents drive out_tdata
// the dot/line/mode state updates in the same cycle as the result register,
//   a loop from state_r through lcdts_step back into state_r
// reset: synchronous on rst_n low; both stages empty, state and config cleared
// stalls: out_tready low holds the result; the input register still takes one
//   more transfer, then in_tready drops until the result is taken
module lcd_line_timing_stat_irq_core #(
  parameter int unsigned DOTS_PER_LINE = lcdts_pkg::DOTS_PER_LINE_DEF,
  parameter int unsigned VISIBLE_LINES = lcdts_pkg::VISIBLE_LINES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lcdts_pkg::IN_DATA_W-1:0]     in_tdata,   // [8:0] tick_count, rest zero
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] line_number, [9:8] mode, [10] lyc_equal, [11] vblank_request,
  // [12] stat_request, [13] render_valid, [21:14] render_line, [23:22] zero
  output logic [lcdts_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [lcdts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcdts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import lcdts_pkg::*;

  // configuration registers
  logic                lcd_enable_r;
  logic [LYC_W-1:0]    lyc_value_r;
  logic [STATEN_W-1:0] stat_enables_r;
  lcdts_cfg_t          cfg;

  // input stage
  logic              s1_valid_r;
  logic [TICK_W-1:0] s1_tick_r;

  // timing state and result stage
  lcdts_state_t  state_r;
  lcdts_state_t  state_nxt;
  lcdts_result_t result;
  logic          out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic advance;   // result register free to load
  logic step;      // an item moves from input register to result register

  assign advance   = !out_valid_r || out_tready;
  assign step      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcd_enable_r   <= 1'b0;
      lyc_value_r    <= '0;
      stat_enables_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LCD_ENABLE:   lcd_enable_r   <= cfg_wdata[0];
        CFG_LYC_VALUE:    lyc_value_r    <= cfg_wdata[LYC_W-1:0];
        CFG_STAT_ENABLES: stat_enables_r <= cfg_wdata[STATEN_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg.lcd_enable   = lcd_enable_r;
  assign cfg.lyc_value    = lyc_value_r;
  assign cfg.stat_enables = stat_enables_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_tick_r <= in_tdata[TICK_W-1:0];
    end
  end

  lcdts_step #(
    .DOTS_PER_LINE (DOTS_PER_LINE),
    .VISIBLE_LINES (VISIBLE_LINES)
  ) u_step (
    .tick_count (s1_tick_r),
    .cfg        (cfg),
    .state      (state_r),
    .state_nxt  (state_nxt),
    .result     (result)
  );

  // timing state only moves when an item is stepped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.dot       <= '0;
      state_r.line      <= '0;
      state_r.mode      <= MODE_HBLANK;
      state_r.last_mode <= NO_MODE;
      state_r.cmatch    <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= {2'b00, result.render_line, result.render_valid,
                     result.stat_request, result.vblank_request,
                     result.lyc_equal, result.mode, result.line_number};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/lcdts_checker.sv =====
// lcdts_checker: port-level checks for the lcd line timing core, with its bind
module lcdts_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [lcdts_pkg::OUT_DATA_W-1:0] out_tdata
);
  import lcdts_pkg::*;

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a finished visible line is the one just before the current line
  a_render_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |->
      (out_tdata[7:0] == out_tdata[21:14] + 8'd1) || (out_tdata[7:0] == 8'd0))
    else $error("render_line does not match line advance");

  // no render index without a render request
  a_render_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[13] |-> out_tdata[21:14] == 8'd0)
    else $error("render_line set without render_valid");

  // vblank entry leaves the block in vblank mode
  a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tdata[9:8] == MODE_VBLANK)
    else $error("vblank request outside vblank mode");

  // line counter stays within the frame
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] <= LAST_LINE)
    else $error("line number past last line");

endmodule

bind lcd_line_timing_stat_irq_core lcdts_checker u_lcdts_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/tb_lcd_line_timing_stat_irq_core.sv =====
// testbench for lcd_line_timing_stat_irq_core: predicted scanline status checked per transfer
`timescale 1ns / 1ps

module tb_lcd_line_timing_stat_irq_core;
  import lcdts_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned RANDOM_TICKS = 1250;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [8:0] tick_count
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [7:0] line_number, [9:8] mode, [10] lyc_equal, [11] vblank_request,
  // [12] stat_request, [13] render_valid, [21:14] render_line
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  lcd_line_timing_stat_irq_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // tick counts waiting to be sent, and the line status each accepted one must produce
  logic [TICK_W-1:0] tick_backlog[$];
  lcdts_result_t     line_status_q[$];

  // shadow of the timing state and the register file
  int unsigned       dot_q;
  int unsigned       line_q;
  logic [MODE_W-1:0] mode_q;
  logic [LMODE_W-1:0] seen_mode;
  bit                match_q;
  bit                en_q;
  logic [LYC_W-1:0]  lyc_q;
  logic [STATEN_W-1:0] sten_q;

  // run bookkeeping
  int  errors;
  int  n_in, n_out, n_vblank, n_stat, n_render, n_phases;
  bit  in_took;
  bit  calm;          // no random idling on either side while set
  bit  long_hold_done;
  int  quiet;
  int  src_gap, sink_gap, sink_hold;

  initial begin
    dot_q     = 0;
    line_q    = 0;
    mode_q    = MODE_HBLANK;
    seen_mode = NO_MODE;
    match_q   = 0;
    en_q      = 0;
    lyc_q     = '0;
    sten_q    = '0;
  end

  // enter a mode; a stat request only on a real change with its enable set
  function automatic bit switch_mode(input logic [MODE_W-1:0] m);
    bit fire;
    fire   = 0;
    mode_q = m;
    if ({1'b0, m} != seen_mode) begin
      seen_mode = {1'b0, m};
      case (m)
        MODE_HBLANK: fire = sten_q[STAT_EN_HBLANK];
        MODE_VBLANK: fire = sten_q[STAT_EN_VBLANK];
        MODE_OAM:    fire = sten_q[STAT_EN_OAM];
        default:     fire = 0;   // drawing has no enable
      endcase
    end
    return fire;
  endfunction

  // advance the shadow timing by one tick transfer and return the status it yields
  function automatic lcdts_result_t advance_timing(input logic [TICK_W-1:0] ticks);
    lcdts_result_t r;
    int unsigned   t;
    bit            stat;
    r    = '0;
    stat = 0;
    if (!en_q) begin
      // display off: counters and mode cleared, edge memories kept
      dot_q  = 0;
      line_q = 0;
      mode_q = MODE_HBLANK;
    end else begin
      // oversized counts saturate, so at most one line ends per transfer
      t = (ticks > DOTS_PER_LINE_DEF) ? DOTS_PER_LINE_DEF : ticks;
      dot_q += t;
      if (dot_q >= DOTS_PER_LINE_DEF) begin
        dot_q -= DOTS_PER_LINE_DEF;
        if (line_q < VISIBLE_LINES_DEF) begin
          r.render_valid = 1'b1;
          r.render_line  = line_q[LINE_W-1:0];
        end
        line_q++;
        if (line_q == VISIBLE_LINES_DEF) begin
          r.vblank_request = 1'b1;
          stat |= switch_mode(MODE_VBLANK);
        end else if (line_q > LAST_LINE) begin
          line_q = 0;
        end else if (line_q < VISIBLE_LINES_DEF) begin
          stat |= switch_mode(MODE_OAM);
        end
        // line compare, rising edge only
        if (line_q[LINE_W-1:0] == lyc_q) begin
          if (!match_q && sten_q[STAT_EN_LYC]) stat = 1;
          match_q = 1;
        end else begin
          match_q = 0;
        end
      end
      // dot position picks the mode on visible lines
      if (line_q < VISIBLE_LINES_DEF) begin
        if (dot_q < OAM_END_DOT) stat |= switch_mode(MODE_OAM);
        else if (dot_q < DRAW_END_DOT) stat |= switch_mode(MODE_DRAW);
        else stat |= switch_mode(MODE_HBLANK);
      end
    end
    r.line_number  = line_q[LINE_W-1:0];
    r.mode         = mode_q;
    r.lyc_equal    = match_q;
    r.stat_request = stat;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // register write at the falling edge, shadow updated alongside (block is idle)
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LCD_ENABLE:   en_q   = val[0];
      CFG_LYC_VALUE:    lyc_q  = val[LYC_W-1:0];
      CFG_STAT_ENABLES: sten_q = val[STATEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every queued tick has gone in and every status has come out,
  // then let the clock run on past the two-stage pipeline
  task automatic settle();
    while (tick_backlog.size() != 0 || in_tvalid || line_status_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // sender: presents one tick count per transfer, with random idle bursts
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      src_gap   <= 0;
    end else if (!in_tvalid || in_took) begin
      if (src_gap > 0) begin
        in_tvalid <= 1'b0;
        src_gap   <= src_gap - 1;
      end else if (tick_backlog.size() != 0 && (calm || $urandom_range(0, 7) != 0)) begin
        in_tdata  <= IN_DATA_W'(tick_backlog.pop_front());
        in_tvalid <= 1'b1;
      end else begin
        // idle now, and draw a random further idle gap if ticks are still waiting
        in_tvalid <= 1'b0;
        if (tick_backlog.size() != 0) src_gap <= $urandom_range(0, 2);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off while the sender keeps going
  // so the pipeline fills and in_tready drops
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready     <= 1'b0;
      sink_gap       <= 0;
      sink_hold      <= 0;
      long_hold_done <= 1'b0;
    end else if (sink_hold > 0) begin
      out_tready <= 1'b0;
      sink_hold  <= sink_hold - 1;
    end else if (!long_hold_done && n_out > 100 && tick_backlog.size() > 40) begin
      out_tready     <= 1'b0;
      sink_hold      <= 48;
      long_hold_done <= 1'b1;
    end else if (sink_gap > 0) begin
      out_tready <= 1'b0;
      sink_gap   <= sink_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      sink_gap   <= $urandom_range(0, 2);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predict on each input transfer, check each result transfer,
  // and watch for a hung pipeline
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lcdts_result_t want;
    lcdts_result_t got;
    in_took = 0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_took = 1;
        line_status_q.push_back(advance_timing(in_tdata[TICK_W-1:0]));
        n_in++;
      end
      if (out_tvalid && out_tready) begin
        got.line_number    = out_tdata[7:0];
        got.mode           = out_tdata[9:8];
        got.lyc_equal      = out_tdata[10];
        got.vblank_request = out_tdata[11];
        got.stat_request   = out_tdata[12];
        got.render_valid   = out_tdata[13];
        got.render_line    = out_tdata[21:14];
        n_out++;
        if (line_status_q.size() == 0) begin
          $error("result transfer with no status expected (line %0d)", got.line_number);
          errors++;
        end else begin
          want = line_status_q.pop_front();
          check_field("line_number",    want.line_number,    got.line_number);
          check_field("mode",           want.mode,           got.mode);
          check_field("lyc_equal",      want.lyc_equal,      got.lyc_equal);
          check_field("vblank_request", want.vblank_request, got.vblank_request);
          check_field("stat_request",   want.stat_request,   got.stat_request);
          check_field("render_valid",   want.render_valid,   got.render_valid);
          check_field("render_line",    want.render_line,    got.render_line);
          n_vblank += want.vblank_request;
          n_stat   += want.stat_request;
          n_render += want.render_valid;
        end
      end
      if (in_took || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: %0d cycles without a transfer, %0d statuses pending",
                 quiet, line_status_q.size());
        $display("FAIL lcd_line_timing_stat_irq_core");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus: directed phases, then randomly configured phases of random ticks
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned queued;
    int unsigned nitems;
    bit          en_pick;
    logic [LYC_W-1:0]    lyc_pick;
    logic [STATEN_W-1:0] sten_pick;
    logic [TICK_W-1:0]   t;
    errors   = 0;
    n_in     = 0;
    n_out    = 0;
    n_vblank = 0;
    n_stat   = 0;
    n_render = 0;
    n_phases = 0;
    quiet    = 0;
    calm     = 0;
    queued   = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // display still off: any tick count gives line 0, mode 0, no requests
    write_reg(CFG_STAT_ENABLES, 8'h0F);
    write_reg(CFG_LYC_VALUE, 8'd0);
    tick_backlog.push_back(9'd456);
    tick_backlog.push_back(9'd511);
    tick_backlog.push_back(9'd0);
    settle();
    n_phases++;

    // display on, walk the mode thresholds of the first lines
    write_reg(CFG_LYC_VALUE, 8'd2);
    write_reg(CFG_LCD_ENABLE, 8'd1);
    tick_backlog.push_back(9'd0);     // first oam entry
    tick_backlog.push_back(9'd79);
    tick_backlog.push_back(9'd1);     // dot 80: drawing, never a stat request
    tick_backlog.push_back(9'd171);
    tick_backlog.push_back(9'd1);     // dot 252: hblank
    tick_backlog.push_back(9'd203);
    tick_backlog.push_back(9'd1);     // line boundary back to oam
    tick_backlog.push_back(9'd456);   // full line, lands on the compare line
    tick_backlog.push_back(9'd455);
    tick_backlog.push_back(9'd456);   // boundary oam and hblank in one transfer
    tick_backlog.push_back(9'd511);   // saturates to a full line
    tick_backlog.push_back(9'd457);
    tick_backlog.push_back(9'd256);
    tick_backlog.push_back(9'd128);
    tick_backlog.push_back(9'd64);
    tick_backlog.push_back(9'd32);
    tick_backlog.push_back(9'd16);
    tick_backlog.push_back(9'd8);
    tick_backlog.push_back(9'd4);
    tick_backlog.push_back(9'd2);
    settle();
    n_phases++;

    // random phases; the line counter carries over while the display stays on, so frames span phases
    while (queued < RANDOM_TICKS) begin
      settle();
      calm = (RANDOM_TICKS - queued <= 150) || (n_phases % 4 == 3);
      en_pick = calm || ($urandom_range(0, 7) != 0);
      case ($urandom_range(0, 3))
        0:       lyc_pick = 8'd0;
        1:       lyc_pick = LAST_LINE;
        2:       lyc_pick = LYC_W'($urandom_range(0, 153));
        default: lyc_pick = LYC_W'($urandom_range(0, 255));
      endcase
      sten_pick = STATEN_W'($urandom_range(0, 15));
      // pin the extremes early in the random part
      if (n_phases == 2) begin
        lyc_pick  = 8'd255;
        sten_pick = 4'h0;
      end else if (n_phases == 3) begin
        lyc_pick  = 8'd143;
        sten_pick = 4'hF;
      end
      write_reg(CFG_LCD_ENABLE, 8'(en_pick));
      write_reg(CFG_LYC_VALUE, lyc_pick);
      write_reg(CFG_STAT_ENABLES, 8'(sten_pick));
      nitems = en_pick ? $urandom_range(60, 200) : $urandom_range(5, 20);
      repeat (nitems) begin
        // mostly long steps so frames complete, some short ones to sit on thresholds
        case ($urandom_range(0, 9))
          0, 1, 2: t = TICK_W'($urandom_range(300, 456));
          3:       t = 9'd456;
          4:       t = TICK_W'($urandom_range(457, 511));
          5, 6:    t = TICK_W'($urandom_range(0, 90));
          7:       t = TICK_W'($urandom_range(150, 260));
          default: t = TICK_W'($urandom_range(0, 511));
        endcase
        tick_backlog.push_back(t);
        if (en_pick) queued++;
      end
      n_phases++;
    end

    settle();
    repeat (6) @(posedge clk);
    if (line_status_q.size() != 0) begin
      $error("%0d expected statuses never arrived", line_status_q.size());
      errors++;
    end
    $display("covered %0d tick transfers over %0d register settings", n_in, n_phases);
    $display("seen %0d rendered lines, %0d vblank entries, %0d stat requests",
             n_render, n_vblank, n_stat);
    if (errors == 0) begin
      $display("PASS lcd_line_timing_stat_irq_core");
    end else begin
      $display("FAIL lcd_line_timing_stat_irq_core");
    end
    $finish;
  end

endmodule
